>>> sv/sobel_energy_map_top_macros.svh
// ----------------------------------------------------------------------------
// sobel_energy_map_top_macros
// assertion macros for the energy map block, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SOBEL_ENERGY_MAP_TOP_MACROS_SVH
`define SOBEL_ENERGY_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SEM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SEM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared beat types and codes of the sobel energy map
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int ENERGY_W = 19;
    localparam int CH_W     = 3;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 16;
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 16;

    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_CHANNELS = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] chan3;
        logic [7:0] chan2;
        logic [7:0] chan1;
        logic [7:0] chan0;
    } sem_in_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                frame_end;
    } sem_out_t;

    typedef struct packed {
        logic start;
        logic lc_left;
        logic mc_right;
    } sem_lane_ctrl_t;

endpackage

>>> sv/sem_line_store.sv
// ----------------------------------------------------------------------------
// sem_line_store
// upper and middle line stores in one memory word, registered read
// ----------------------------------------------------------------------------
module sem_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sem_lane.sv
// ----------------------------------------------------------------------------
// sem_lane
// one channel: sobel gradients, squared sum, bit-serial square root
// ----------------------------------------------------------------------------
module sem_lane #(
    parameter int FRACTION_BITS = 8,
    parameter int ROOT_W        = (21 + 2 * FRACTION_BITS + 1) / 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sem_pkg::sem_lane_ctrl_t ctrl,
    input  logic [8:0][7:0]         win,
    output logic [ROOT_W-1:0]       root,
    output logic                    done
);
    import sem_pkg::*;

    localparam int SQ_W  = 21;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [9:0]        l_col, r_col, t_row, b_row;
    logic [9:0]        ax, ay;
    logic [19:0]       px, py;
    logic [SQ_W-1:0]   sq;
    logic [7:0]        s_tl, s_ml, s_bl, s_tm, s_bm;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    logic [REM_W+1:0]  rem2, trial, diff;
    logic              ge;

    always_comb begin
        s_tl  = ctrl.lc_left ? win[0] : win[1];
        s_ml  = ctrl.lc_left ? win[3] : win[4];
        s_bl  = ctrl.lc_left ? win[6] : win[7];
        s_tm  = ctrl.mc_right ? win[2] : win[1];
        s_bm  = ctrl.mc_right ? win[8] : win[7];
        l_col = 10'(s_tl) + {1'b0, s_ml, 1'b0} + 10'(s_bl);
        r_col = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(win[8]);
        t_row = 10'(s_tl) + {1'b0, s_tm, 1'b0} + 10'(win[2]);
        b_row = 10'(s_bl) + {1'b0, s_bm, 1'b0} + 10'(win[8]);
        ax    = (r_col >= l_col) ? r_col - l_col : l_col - r_col;
        ay    = (b_row >= t_row) ? b_row - t_row : t_row - b_row;
        px    = 20'(ax) * 20'(ax);
        py    = 20'(ay) * 20'(ay);
        sq    = {1'b0, px} + {1'b0, py};
        rem2  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = rem2 >= trial;
        diff  = rem2 - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rad_reg  <= RAD_W'(sq) << (2 * FRACTION_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> sv/sem_merge.sv
// ----------------------------------------------------------------------------
// sem_merge
// sums the used lanes and divides by the channel count, one bit a cycle
// ----------------------------------------------------------------------------
module sem_merge #(
    parameter int MAX_CHANNELS = 4,
    parameter int ROOT_W       = 20,
    parameter int SUM_W        = ROOT_W + $clog2(MAX_CHANNELS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [sem_pkg::CH_W-1:0]            nch,
    input  logic [MAX_CHANNELS-1:0][ROOT_W-1:0] roots,
    output logic [SUM_W-1:0]                    quot,
    output logic                                done
);
    import sem_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] div_reg;
    logic [CH_W-1:0]  rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [CH_W:0]    rem2, dvs;
    logic             ge;

    always_comb begin
        sum = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (CH_W'(i) < nch) begin
                sum = sum + SUM_W'(roots[i]);
            end
        end
        rem2 = {rem_reg, div_reg[SUM_W-1]};
        dvs  = {1'b0, nch};
        ge   = rem2 >= dvs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= sum;
            rem_reg <= '0;
        end else if (busy_reg) begin
            div_reg <= {div_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? CH_W'(rem2 - dvs) : rem2[CH_W-1:0];
        end
    end

    assign quot = div_reg;
    assign done = done_reg;

endmodule

>>> sv/sobel_energy_map_top.sv
// ----------------------------------------------------------------------------
// sobel_energy_map_top
// streaming 3x3 sobel gradient magnitude energy map, one lane per channel
// ----------------------------------------------------------------------------
// channel  ports                               beat
// input    s_valid s_ready s_data              command and four 8-bit samples
// result   m_valid m_ready m_data              energy and frame_end
// config   cfg_valid cfg_ready cfg_index/data  register write
//
// an item with a result holds off the next accept through the bit-serial root
// in the lanes and the serial divide in the merge
// an item without a result holds it off through the line store read and update,
// an ignored drain through the line store read alone
// aresetn is synchronous; line stores are not cleared
// a waiting result does not block the next item, only the one after it
// ----------------------------------------------------------------------------
`include "sobel_energy_map_top_macros.svh"

module sobel_energy_map_top #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_CHANNELS  = 4,
    parameter int FRACTION_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sem_pkg::sem_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sem_pkg::sem_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sem_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]   cfg_data
);
    import sem_pkg::*;

    localparam int PIX_W  = 8 * MAX_CHANNELS;
    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);
    localparam int ROOT_W = (21 + 2 * FRACTION_BITS + 1) / 2;
    localparam int SUM_W  = ROOT_W + $clog2(MAX_CHANNELS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IMG_W_W-1:0]  width_reg;
    logic [IMG_H_W-1:0]  height_reg;
    logic [CH_W-1:0]     chans_reg;

    logic                cmd_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [IMG_H_W-1:0]  row_reg, row_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [PIX_W-1:0]    win_reg [9];
    logic [PIX_W-1:0]    win_next [9];
    logic [PIX_W-1:0]    eval_reg [9];
    logic [PIX_W-1:0]    eval_next [9];
    logic                lc_left_reg, lc_left_next;
    logic                mc_right_reg, mc_right_next;
    logic                fe_reg, fe_next;
    logic                start_reg, start_next;
    logic                has_res;

    logic [COL_W-1:0]    w_eff;
    logic [IMG_H_W-1:0]  h_eff;
    logic [CH_W-1:0]     n_eff;
    logic [COL_W-1:0]    c_prep;

    logic [2*PIX_W-1:0]  rd_data;
    logic [PIX_W-1:0]    u_pix, m_pix, top_pix;
    logic                wr_en, rd_en;

    sem_lane_ctrl_t                         lane_ctrl;
    logic [MAX_CHANNELS-1:0][ROOT_W-1:0]    lane_root;
    logic [MAX_CHANNELS-1:0]                lane_done;
    logic [MAX_CHANNELS-1:0][8:0][7:0]      lane_win;
    logic [SUM_W-1:0]                       merge_quot;
    logic                                   merge_done;

    logic                m_valid_reg;
    sem_out_t            m_data_reg;
    logic                out_load;

    // register clamps
    always_comb begin
        if (width_reg < IMG_W_W'(2)) begin
            w_eff = COL_W'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(width_reg);
        end
        h_eff = (height_reg < IMG_H_W'(2)) ? IMG_H_W'(2) : height_reg;
        if (chans_reg == '0) begin
            n_eff = CH_W'(1);
        end else if (32'(chans_reg) > MAX_CHANNELS) begin
            n_eff = CH_W'(MAX_CHANNELS);
        end else begin
            n_eff = chans_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= IMG_W_W'(640);
            height_reg <= IMG_H_W'(480);
            chans_reg  <= CH_W'(3);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_WIDTH:    width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_IDX_HEIGHT:   height_reg <= cfg_data[IMG_H_W-1:0];
                CFG_IDX_CHANNELS: chans_reg  <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // line stores
    assign c_prep = (cmd_reg == CMD_PIXEL && pend_reg != '0) ? '0 : col_reg;
    assign rd_en  = (state_reg == ST_PREP);
    assign wr_en  = (state_reg == ST_READ) && (cmd_reg == CMD_PIXEL);
    assign u_pix  = rd_data[2*PIX_W-1:PIX_W];
    assign m_pix  = rd_data[PIX_W-1:0];

    always_comb begin
        if (c_prep < COL_W'(MAX_WIDTH)) begin
            addr_next = AW'(c_prep);
        end else begin
            addr_next = AW'(MAX_WIDTH - 1);
        end
    end

    sem_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W),
        .ADDR_W (AW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (addr_next),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data ({m_pix, pix_reg})
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        lc_left_next  = lc_left_reg;
        mc_right_next = mc_right_reg;
        fe_next       = fe_reg;
        start_next    = 1'b0;
        has_res       = 1'b0;
        top_pix       = (row_reg == IMG_H_W'(1)) ? m_pix : u_pix;
        for (int k = 0; k < 9; k++) begin
            win_next[k]  = win_reg[k];
            eval_next[k] = eval_reg[k];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (cmd_reg == CMD_PIXEL) begin
                    if (pend_reg != '0) begin
                        pend_next = '0;
                        col_next  = '0;
                        row_next  = '0;
                    end
                    state_next = ST_READ;
                end else if (pend_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (cmd_reg == CMD_PIXEL) begin
                    for (int r = 0; r < 3; r++) begin
                        win_next[r*3]   = win_reg[r*3+1];
                        win_next[r*3+1] = win_reg[r*3+2];
                    end
                    win_next[2] = top_pix;
                    win_next[5] = m_pix;
                    win_next[8] = pix_reg;
                    fe_next     = 1'b0;
                    if (col_reg == '0 && row_reg >= IMG_H_W'(2)) begin
                        has_res = 1'b1;
                        for (int k = 0; k < 9; k++) begin
                            eval_next[k] = win_reg[k];
                        end
                        lc_left_next  = 1'b0;
                        mc_right_next = 1'b1;
                    end
                    if (col_reg != '0 && row_reg != '0) begin
                        has_res = 1'b1;
                        for (int k = 0; k < 9; k++) begin
                            eval_next[k] = win_next[k];
                        end
                        lc_left_next  = (col_reg != COL_W'(1));
                        mc_right_next = 1'b0;
                    end
                    if (col_reg >= w_eff - 1'b1) begin
                        col_next = '0;
                        if (row_reg >= h_eff - 1'b1) begin
                            row_next  = '0;
                            pend_next = PEND_W'(w_eff) + 1'b1;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end else begin
                    has_res = 1'b1;
                    if (col_reg < w_eff) begin
                        for (int r = 0; r < 3; r++) begin
                            win_next[r*3]   = win_reg[r*3+1];
                            win_next[r*3+1] = win_reg[r*3+2];
                        end
                        win_next[2] = u_pix;
                        win_next[5] = m_pix;
                        win_next[8] = m_pix;
                    end
                    if (col_reg == '0 || col_reg >= w_eff) begin
                        for (int k = 0; k < 9; k++) begin
                            eval_next[k] = win_reg[k];
                        end
                        lc_left_next  = 1'b0;
                        mc_right_next = 1'b1;
                    end else begin
                        for (int k = 0; k < 9; k++) begin
                            eval_next[k] = win_next[k];
                        end
                        lc_left_next  = (col_reg != COL_W'(1));
                        mc_right_next = 1'b0;
                    end
                    fe_next   = (pend_reg == PEND_W'(1));
                    pend_next = pend_reg - 1'b1;
                    col_next  = col_reg + 1'b1;
                    if (pend_reg == PEND_W'(1)) begin
                        col_next = '0;
                        row_next = '0;
                    end
                end
                if (has_res) begin
                    start_next = 1'b1;
                    state_next = ST_CALC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALC: begin
                if (merge_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data.command;
            pix_reg <= PIX_W'({s_data.chan3, s_data.chan2, s_data.chan1, s_data.chan0});
        end
        if (state_reg == ST_PREP) begin
            addr_reg <= addr_next;
        end
        for (int k = 0; k < 9; k++) begin
            win_reg[k]  <= win_next[k];
            eval_reg[k] <= eval_next[k];
        end
        lc_left_reg  <= lc_left_next;
        mc_right_reg <= mc_right_next;
        fe_reg       <= fe_next;
    end

    // lanes
    assign lane_ctrl.start    = start_reg;
    assign lane_ctrl.lc_left  = lc_left_reg;
    assign lane_ctrl.mc_right = mc_right_reg;

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        for (genvar k = 0; k < 9; k++) begin : g_tap
            assign lane_win[i][k] = eval_reg[k][8*i +: 8];
        end

        sem_lane #(
            .FRACTION_BITS (FRACTION_BITS),
            .ROOT_W        (ROOT_W)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .win     (lane_win[i]),
            .root    (lane_root[i]),
            .done    (lane_done[i])
        );
    end

    sem_merge #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .ROOT_W       (ROOT_W),
        .SUM_W        (SUM_W)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (&lane_done),
        .nch     (n_eff),
        .roots   (lane_root),
        .quot    (merge_quot),
        .done    (merge_done)
    );

    // result register
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.energy    <= ENERGY_W'(merge_quot);
            m_data_reg.frame_end <= fe_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SEM_ASSERT_IMP(a_frame_end_empty, aclk, aresetn, out_load && fe_reg, pend_reg == '0)
    `SEM_ASSERT_IMP(a_merge_in_calc, aclk, aresetn, merge_done, state_reg == ST_CALC)
    `SEM_ASSERT_IMP(a_col_bound, aclk, aresetn, state_reg == ST_IDLE, col_reg <= COL_W'(MAX_WIDTH))
    `SEM_ASSERT_NXT(a_idle_drain, aclk, aresetn, (state_reg == ST_PREP) && (cmd_reg == CMD_DRAIN) && (pend_reg == '0), state_reg == ST_IDLE)

endmodule

>>> tb/sobel_energy_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_energy_map_top_tb
// directed and randomised frames through the energy map, scored against a behavioural
// model of the line stores, the sobel window and the per-channel root
// ----------------------------------------------------------------------------

class energy_board;
    int unsigned img_w, img_h, n_chan;
    bit [31:0] upper_st [1024];
    bit [31:0] middle_st [1024];
    bit [31:0] win [9];
    int unsigned col, row, pending;
    sem_pkg::sem_out_t energy_q [$];
    int errors;

    function new();
        img_w = 640; img_h = 480; n_chan = 3;
        col = 0; row = 0; pending = 0; errors = 0;
        foreach (win[i]) win[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            sem_pkg::CFG_IDX_WIDTH:    img_w = val[10:0];
            sem_pkg::CFG_IDX_HEIGHT:   img_h = val;
            sem_pkg::CFG_IDX_CHANNELS: n_chan = val[2:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_w();
        return img_w < 2 ? 2 : (img_w > 1024 ? 1024 : img_w);
    endfunction

    function int unsigned eff_h();
        return img_h < 2 ? 2 : img_h;
    endfunction

    function int unsigned eff_c();
        return n_chan < 1 ? 1 : (n_chan > 4 ? 4 : n_chan);
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned rem, root, b;
        rem = v; root = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function int px(int r, int c, int ch);
        return int'((win[r*3+c] >> (8*ch)) & 32'hff);
    endfunction

    function bit [18:0] grad_energy(int lc, int mc, int rc);
        longint unsigned acc;
        int gx, gy;
        acc = 0;
        for (int ch = 0; ch < eff_c(); ch++) begin
            gx = (px(0,rc,ch) + 2*px(1,rc,ch) + px(2,rc,ch))
               - (px(0,lc,ch) + 2*px(1,lc,ch) + px(2,lc,ch));
            gy = (px(2,lc,ch) + 2*px(2,mc,ch) + px(2,rc,ch))
               - (px(0,lc,ch) + 2*px(0,mc,ch) + px(0,rc,ch));
            acc += isqrt(longint'(gx*gx + gy*gy) << 16);
        end
        return 19'(acc / eff_c());
    endfunction

    function void shift_col(bit [31:0] t, bit [31:0] m, bit [31:0] b);
        bit [31:0] cv [3];
        cv[0] = t; cv[1] = m; cv[2] = b;
        for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = cv[r];
        end
    endfunction

    function void note_input(sem_pkg::sem_in_t d);
        int unsigned w, h, c, r, ci;
        bit [31:0] u, m, x;
        bit [18:0] e;
        bit hit;
        sem_pkg::sem_out_t o;
        w = eff_w(); h = eff_h(); hit = 0; e = '0;
        if (d.command == sem_pkg::CMD_PIXEL) begin
            x = {d.chan3, d.chan2, d.chan1, d.chan0};
            if (pending != 0) begin
                pending = 0; col = 0; row = 0;
            end
            c = col; r = row; ci = c < 1024 ? c : 1023;
            u = upper_st[ci]; m = middle_st[ci];
            upper_st[ci] = m; middle_st[ci] = x;
            if (c == 0 && r >= 2) begin
                e = grad_energy(1, 2, 2); hit = 1;
            end
            shift_col(r == 1 ? m : u, m, x);
            if (c >= 1 && r >= 1) begin
                e = (c == 1) ? grad_energy(1, 1, 2) : grad_energy(0, 1, 2);
                hit = 1;
            end
            if (c >= w - 1) begin
                col = 0;
                if (r >= h - 1) begin
                    row = 0; pending = w + 1;
                end else begin
                    row = r + 1;
                end
            end else begin
                col = c + 1;
            end
            if (hit) begin
                o.energy = e; o.frame_end = 1'b0;
                energy_q.push_back(o);
            end
            return;
        end
        if (pending == 0) return;
        c = col;
        if (c < w) begin
            ci = c < 1024 ? c : 1023;
            u = upper_st[ci]; m = middle_st[ci];
        end else begin
            u = '0; m = '0;
        end
        if (c == 0) begin
            e = grad_energy(1, 2, 2);
            shift_col(u, m, m);
        end else if (c < w) begin
            shift_col(u, m, m);
            e = (c == 1) ? grad_energy(1, 1, 2) : grad_energy(0, 1, 2);
        end else begin
            e = grad_energy(1, 2, 2);
        end
        o.energy = e; o.frame_end = (pending == 1);
        energy_q.push_back(o);
        pending--;
        col = c + 1;
        if (pending == 0) begin
            col = 0; row = 0;
        end
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_result(sem_pkg::sem_out_t got);
        sem_pkg::sem_out_t want;
        if (energy_q.size() == 0) begin
            report($sformatf("unexpected result beat energy=%0d", got.energy));
            return;
        end
        want = energy_q.pop_front();
        if (got.energy !== want.energy) begin
            report($sformatf("energy %0d, expected %0d", got.energy, want.energy));
        end
        if (got.frame_end !== want.frame_end) begin
            report($sformatf("frame_end %0b, expected %0b", got.frame_end, want.frame_end));
        end
    endtask
endclass

module sobel_energy_map_top_tb;
    import sem_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sem_in_t s_data;
    logic m_valid;
    logic m_ready;
    sem_out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    energy_board board;
    bit stim_done;
    int idle_cycles;
    int n_items;

    sobel_energy_map_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
    endtask

    task automatic send_beat(logic cmd, logic [31:0] pix);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {cmd, pix};
        do @(posedge aclk); while (!s_ready);
        board.note_input(s_data);
        n_items++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.energy_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // one frame; mode 0 random, 1 flat, 2 extremes, 3 checker
    task automatic send_frame(int w, int h, int mode, bit drain);
        logic [31:0] p;
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                1: p = 32'h80808080;
                2: p = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h0;
                3: p = (((i % w) + (i / w)) % 2 != 0) ? 32'hffffffff : 32'h0;
                default: p = $urandom;
            endcase
            send_beat(CMD_PIXEL, p);
        end
        if (drain) begin
            for (int i = 0; i < w + 1; i++) send_beat(CMD_DRAIN, $urandom);
        end
    endtask

    task automatic setup(int w, int h, int ch);
        s_valid <= 1'b0;
        write_reg(CFG_IDX_WIDTH, CFG_W'(w));
        write_reg(CFG_IDX_HEIGHT, CFG_W'(h));
        write_reg(CFG_IDX_CHANNELS, CFG_W'(ch));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stim_done = 1'b0;
        n_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stray drain, tiny frames, extremes, clamped registers
        send_beat(CMD_DRAIN, 32'h0);
        setup(2, 2, 4);
        send_frame(2, 2, 2, 1);
        send_beat(CMD_DRAIN, 32'h0);
        wait_drained();
        setup(0, 0, 0);
        send_frame(2, 2, 3, 1);
        wait_drained();
        setup(3, 3, 7);
        send_frame(3, 3, 3, 0);
        // pixel while pending restarts the frame
        send_frame(3, 3, 2, 1);
        wait_drained();

        while (n_items < 845) begin
            int w, h, ch;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 24) : $urandom_range(2, 6);
            h = $urandom_range(2, 5);
            ch = $urandom_range(1, 4);
            setup(w, h, ch);
            send_frame(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                       $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 5) == 0) send_beat(CMD_DRAIN, $urandom);
            wait_drained();
        end

        // width beyond its limit and the largest height
        setup(2047, 65535, 4);
        send_frame(2, 1, 0, 0);
        wait_drained();
        stim_done = 1'b1;
    end

    initial begin
        int wait_n;
        wait_n = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_result(m_data);
                wait_n = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) wait_n = 0;
            end
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                wait_n--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done) begin
                if (board.errors == 0 && board.energy_q.size() == 0)
                    $display("PASSED: all results match");
                else
                    $display("FAILED: results differ");
                $finish;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: watchdog, %0d results outstanding", board.energy_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end
endmodule
